@@ rtl/nmde_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmde_pkg
// Shared types and constants of the neighbour max-difference edge RLE block.
// ----------------------------------------------------------------------------
package nmde_pkg;

	localparam int PIX_W      = 8;
	localparam int RUN_W      = 21;
	localparam int NB         = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;
	localparam int CFG_W      = 11;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;

	typedef struct packed {
		logic             valid;
		logic             evt;
		logic             compute;
		logic             final_run;
		logic             wrap;
		logic             left_ok;
		logic             top_ok;
		logic             mid_ok;
		logic             bot_ok;
		logic [PIX_W-1:0] pix;
	} ev_t;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		logic             top_ok;
		logic             mid_ok;
		logic             bot_ok;
	} col_t;

	typedef struct packed {
		logic                     valid;
		logic                     compute;
		logic                     final_run;
		logic [NB-1:0][PIX_W-1:0] diff;
	} dif_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic [RUN_W-1:0] run_length;
		logic             last_run;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/nmde_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmde_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nmde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/nmde_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmde_window
// Column read-modify-write of the row buffers, 3x3 window and the
// absolute neighbour differences of the centre pixel.
// ----------------------------------------------------------------------------
module nmde_window #(
	parameter int ADDR_W = 10
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  nmde_pkg::ev_t         ev,
	input  wire  [ADDR_W-1:0]           ev_addr,
	input  wire  [2*nmde_pkg::PIX_W-1:0] ram_rdata,
	output logic                        ram_we,
	output logic [ADDR_W-1:0]           ram_waddr,
	output logic [2*nmde_pkg::PIX_W-1:0] ram_wdata,
	output logic                        s1_valid,
	output nmde_pkg::dif_t              dif
);

	nmde_pkg::ev_t                  ev_s1;
	logic [ADDR_W-1:0]              addr_s1;
	logic                           fwd_s1;
	logic [2*nmde_pkg::PIX_W-1:0]   fwd_data_s1;
	nmde_pkg::col_t                 col_a_q;
	nmde_pkg::col_t                 col_b_q;
	logic [2*nmde_pkg::PIX_W-1:0]   rd;
	nmde_pkg::col_t                 col_x;
	logic [nmde_pkg::NB-1:0][nmde_pkg::PIX_W-1:0] nb_val;
	logic [nmde_pkg::NB-1:0]        nb_ok;
	logic [nmde_pkg::NB-1:0][nmde_pkg::PIX_W-1:0] diff;
	logic [nmde_pkg::PIX_W-1:0]     centre;

	assign rd = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		col_x.top    = rd[2*nmde_pkg::PIX_W-1:nmde_pkg::PIX_W];
		col_x.mid    = rd[nmde_pkg::PIX_W-1:0];
		col_x.bot    = ev_s1.pix;
		col_x.top_ok = ev_s1.top_ok;
		col_x.mid_ok = ev_s1.mid_ok;
		col_x.bot_ok = ev_s1.bot_ok;
	end

	assign ram_we    = ev_s1.valid && ev_s1.evt;
	assign ram_waddr = addr_s1;
	assign ram_wdata = {rd[nmde_pkg::PIX_W-1:0], ev_s1.pix};
	assign s1_valid  = ev_s1.valid;
	assign centre    = col_b_q.mid;

	always_comb begin
		nb_val[0] = col_a_q.top;
		nb_val[1] = col_a_q.mid;
		nb_val[2] = col_a_q.bot;
		nb_val[3] = col_b_q.top;
		nb_val[4] = col_b_q.bot;
		nb_val[5] = col_x.top;
		nb_val[6] = col_x.mid;
		nb_val[7] = col_x.bot;
		nb_ok[0]  = ev_s1.left_ok && col_a_q.top_ok;
		nb_ok[1]  = ev_s1.left_ok && col_a_q.mid_ok;
		nb_ok[2]  = ev_s1.left_ok && col_a_q.bot_ok;
		nb_ok[3]  = col_b_q.top_ok;
		nb_ok[4]  = col_b_q.bot_ok;
		nb_ok[5]  = !ev_s1.wrap && col_x.top_ok;
		nb_ok[6]  = !ev_s1.wrap && col_x.mid_ok;
		nb_ok[7]  = !ev_s1.wrap && col_x.bot_ok;
		for (int i = 0; i < nmde_pkg::NB; i++) begin
			if (!nb_ok[i]) begin
				diff[i] = '0;
			end else if (nb_val[i] > centre) begin
				diff[i] = nb_val[i] - centre;
			end else begin
				diff[i] = centre - nb_val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1  <= '0;
			fwd_s1 <= 1'b0;
			dif    <= '0;
		end else begin
			ev_s1         <= ev;
			fwd_s1        <= ev.valid && ev.evt && ev_s1.valid && ev_s1.evt
				&& (addr_s1 == ev_addr);
			dif.valid     <= ev_s1.valid;
			dif.compute   <= ev_s1.compute;
			dif.final_run <= ev_s1.final_run;
			dif.diff      <= diff;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= ev_addr;
		fwd_data_s1 <= ram_wdata;
		if (ev_s1.valid && ev_s1.evt) begin
			col_a_q <= col_b_q;
			col_b_q <= col_x;
		end
	end

endmodule
`default_nettype wire

@@ rtl/nmde_rle.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nmde_rle
// Maximum of the neighbour differences, run-length packing and the
// result FIFO in front of the output stream.
// ----------------------------------------------------------------------------
module nmde_rle #(
	parameter int CNT_W = 21
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  nmde_pkg::dif_t               dif,
	output logic                               out_valid,
	input  wire                                out_ready,
	output nmde_pkg::res_t                     out_res,
	output logic [nmde_pkg::FIFO_CNT_W-1:0]    fill
);

	logic [nmde_pkg::PIX_W-1:0] m1 [4];
	logic [nmde_pkg::PIX_W-1:0] m2 [2];
	logic [nmde_pkg::PIX_W-1:0] edge_max;
	logic [nmde_pkg::PIX_W-1:0] open_val_q;
	logic [CNT_W-1:0]           open_len_q;
	logic                       brk;
	logic                       push;
	logic                       pop;
	nmde_pkg::res_t             push_res;
	nmde_pkg::res_t             fifo_q [nmde_pkg::FIFO_DEPTH];
	logic [nmde_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [nmde_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [nmde_pkg::FIFO_CNT_W-1:0] cnt_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			m1[i] = (dif.diff[2*i] > dif.diff[2*i+1]) ? dif.diff[2*i] : dif.diff[2*i+1];
		end
		for (int i = 0; i < 2; i++) begin
			m2[i] = (m1[2*i] > m1[2*i+1]) ? m1[2*i] : m1[2*i+1];
		end
		edge_max = (m2[0] > m2[1]) ? m2[0] : m2[1];
	end

	assign brk  = (open_len_q != '0) && (edge_max != open_val_q);
	assign push = dif.valid && ((dif.compute && brk) || dif.final_run);
	assign pop  = out_valid && out_ready;

	always_comb begin
		push_res.edge_value = open_val_q;
		push_res.run_length = nmde_pkg::RUN_W'(open_len_q);
		push_res.last_run   = dif.final_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_val_q <= '0;
			open_len_q <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
		end else begin
			if (dif.valid && dif.final_run) begin
				open_val_q <= '0;
				open_len_q <= '0;
			end else if (dif.valid && dif.compute) begin
				open_val_q <= edge_max;
				open_len_q <= brk ? CNT_W'(1) : open_len_q + CNT_W'(1);
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_res;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_res   = fifo_q[rd_ptr_q];
	assign fill      = cnt_q;

endmodule
`default_nettype wire

@@ rtl/neighbour_max_difference_edge_rle.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neighbour_max_difference_edge_rle
// Max neighbour-difference edge detector over a raster pixel stream with
// run-length coded output; one row-buffer RAM holds the two previous rows.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the result FIFO has room and no
// fill-in runs, limited by the row-buffer RAM port. A run leaves through the window stage
// register, the difference register and the result FIFO after the pixel or flush that closes it.
// The first flush of an image with fewer than width+1 pixels holds tready low while the window is filled.
// Reset clears all counters and the run; image_width resets to 1024.
// Row-buffer contents are not cleared.
// ----------------------------------------------------------------------------
module neighbour_max_difference_edge_rle #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] pixel_value
	input  wire         s_tuser,   // [0] func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] edge_value, [28:8] run_length
	output logic        m_tlast,   // last_run
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam longint unsigned LIMIT = longint'(MAX_WIDTH) * longint'(MAX_ROWS);
	localparam int NW     = $clog2(LIMIT + longint'(MAX_WIDTH) + 2);
	localparam int AW     = $clog2(MAX_WIDTH + 1);
	localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW     = (AW > nmde_pkg::CFG_W) ? AW : nmde_pkg::CFG_W;

	logic [nmde_pkg::CFG_W-1:0] img_width_q;
	logic [AW-1:0]              act_w_q;
	logic [NW-1:0]              rcv_q;
	logic [NW-1:0]              done_q;
	logic [NW-1:0]              ev_q;
	logic [CW-1:0]              col_q;
	logic [1:0]                 row_q;
	logic                       drain_q;

	logic [XW-1:0]              cfg_x;
	logic [AW-1:0]              clamp_w;
	logic [AW-1:0]              wn;
	logic                       cu;
	logic                       room;
	logic                       acc;
	logic                       is_pix;
	logic                       is_flush;
	logic                       fl_step;
	logic                       fl_final;
	logic                       ev_fire;
	logic                       col_last;
	nmde_pkg::ev_t              ev;
	logic                       cfg_wr;

	logic                       ram_we;
	logic [CW-1:0]              ram_waddr;
	logic [2*nmde_pkg::PIX_W-1:0] ram_wdata;
	logic [2*nmde_pkg::PIX_W-1:0] ram_rdata;
	logic                       s1_valid;
	nmde_pkg::dif_t             dif;
	nmde_pkg::res_t             out_res;
	logic [nmde_pkg::FIFO_CNT_W-1:0] fill;

	always_comb begin
		cfg_x = XW'(img_width_q);
		if (cfg_x == '0) begin
			clamp_w = AW'(1);
		end else if (cfg_x > XW'(MAX_WIDTH)) begin
			clamp_w = AW'(MAX_WIDTH);
		end else begin
			clamp_w = AW'(cfg_x);
		end
	end

	assign wn = (rcv_q == '0) ? clamp_w : act_w_q;

	assign cu = s_tvalid && (s_tuser == nmde_pkg::FUNC_FLUSH) && (rcv_q != '0)
		&& !drain_q && (ev_q <= NW'(act_w_q));
	assign room = (4'(fill) + 4'(s1_valid) + 4'(dif.valid)) < 4'(nmde_pkg::FIFO_DEPTH);
	assign s_tready = room && !cu;
	assign acc      = s_tvalid && s_tready;
	assign is_pix   = acc && (s_tuser == nmde_pkg::FUNC_PIXEL) && !drain_q
		&& (rcv_q < NW'(LIMIT));
	assign is_flush = acc && (s_tuser == nmde_pkg::FUNC_FLUSH) && (rcv_q != '0);
	assign fl_step  = is_flush && (done_q < rcv_q);
	assign fl_final = is_flush && !fl_step;
	assign ev_fire  = cu || is_pix || fl_step;
	assign col_last = (AW'(col_q) + AW'(1)) == wn;

	always_comb begin
		ev.valid     = ev_fire || fl_final;
		ev.evt       = ev_fire;
		ev.compute   = is_pix ? (ev_q > NW'(wn)) : fl_step;
		ev.final_run = fl_final;
		ev.wrap      = (col_q == '0);
		ev.left_ok   = (col_q == '0) ? (32'(wn) >= 32'd2) : (32'(col_q) >= 32'd2);
		ev.top_ok    = (row_q == 2'd2);
		ev.mid_ok    = is_pix || (ev_q < rcv_q + NW'(wn));
		ev.bot_ok    = is_pix;
		ev.pix       = s_tdata;
	end

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = {{(32 - nmde_pkg::CFG_W){1'b0}}, img_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q <= nmde_pkg::CFG_W'(1024);
			act_w_q     <= AW'(1);
			rcv_q       <= '0;
			done_q      <= '0;
			ev_q        <= '0;
			col_q       <= '0;
			row_q       <= '0;
			drain_q     <= 1'b0;
		end else begin
			if (cfg_wr && (paddr == nmde_pkg::REG_IMAGE_WIDTH)) begin
				img_width_q <= pwdata[nmde_pkg::CFG_W-1:0];
			end
			if (fl_final) begin
				rcv_q   <= '0;
				done_q  <= '0;
				ev_q    <= '0;
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= 1'b0;
			end else begin
				if (is_flush) begin
					drain_q <= 1'b1;
				end
				if (is_pix) begin
					rcv_q <= rcv_q + NW'(1);
					if (rcv_q == '0) begin
						act_w_q <= clamp_w;
					end
				end
				if (ev.compute) begin
					done_q <= done_q + NW'(1);
				end
				if (ev_fire) begin
					ev_q <= ev_q + NW'(1);
					if (col_last) begin
						col_q <= '0;
						if (row_q != 2'd2) begin
							row_q <= row_q + 2'd1;
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
		end
	end

	nmde_ram #(
		.WIDTH (2 * nmde_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ev_fire),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	nmde_window #(
		.ADDR_W (CW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (ev),
		.ev_addr   (col_q),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.s1_valid  (s1_valid),
		.dif       (dif)
	);

	nmde_rle #(
		.CNT_W (NW)
	) u_rle (
		.clk       (clk),
		.arst_n    (arst_n),
		.dif       (dif),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.fill      (fill)
	);

	assign m_tdata = {{(32 - nmde_pkg::RUN_W - nmde_pkg::PIX_W){1'b0}},
		out_res.run_length, out_res.edge_value};
	assign m_tlast = out_res.last_run;

	a_fill_cu_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cu |-> !s_tready) else $error("fill-in sequence accepted an input");
	a_done_le_rcv: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= rcv_q) else $error("more pixels finished than received");
	a_rcv_le_ev: assert property (@(posedge clk) disable iff (!arst_n)
		rcv_q <= ev_q) else $error("window events behind received pixels");
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fl_final |=> (rcv_q == '0) && !drain_q && (ev_q == '0))
		else $error("image state not cleared after final run");
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= nmde_pkg::FIFO_CNT_W'(nmde_pkg::FIFO_DEPTH))
		else $error("result FIFO overflow");

endmodule
`default_nettype wire
